// ===== hdl/face_area_normal_centroid_top_defines.svh =====
// Assertion macros for the face area, normal and centroid pipeline
`ifndef FACE_AREA_NORMAL_CENTROID_TOP_DEFINES_SVH
`define FACE_AREA_NORMAL_CENTROID_TOP_DEFINES_SVH
// check a consequence in the same cycle as its cause
`define FANC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// check a consequence in the cycle after its cause
`define FANC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/fanc_pkg.sv =====
// Shared types and constants of the face area, normal and centroid pipeline
package fanc_pkg;

  localparam int unsigned COORD_BITS_DEF       = 24;
  localparam int unsigned NORMAL_FRAC_BITS_DEF = 15;
  localparam int unsigned AREA_BITS            = 53;
  localparam int unsigned NORMAL_BITS          = 16;

  typedef enum logic {
    FACE_QUAD = 1'b0,
    FACE_TRI  = 1'b1
  } face_kind_e;

  typedef struct packed {
    logic vld;
    logic degen;
  } ctrl_t;

endpackage

// ===== hdl/fanc_front.sv =====
// Front stages: edge vectors, cross product, centroid and sum of squares
module fanc_front #(
  parameter int unsigned CB = fanc_pkg::COORD_BITS_DEF,
  localparam int unsigned MW = 2 * CB + 1,
  localparam int unsigned SW = 2 * (MW + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       in_valid_i,
  input  logic                       tri_i,
  input  logic [3:0][2:0][CB-1:0]    vtx_i,
  output fanc_pkg::ctrl_t            ctrl_o,
  output logic [SW-1:0]              sq_o,
  output logic [2:0][MW-1:0]         mag_o,
  output logic [2:0]                 sgn_o,
  output logic [2:0][CB-1:0]         ctr_o
);
  import fanc_pkg::*;

  localparam int unsigned DW  = CB + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned XW  = PW + 1;
  localparam int unsigned SMW = CB + 2;
  localparam int unsigned UW  = CB + 3;
  localparam int unsigned RPW = 2 * UW - 1;
  localparam int unsigned LW  = (MW + 1) / 2;
  localparam int unsigned HW  = MW - LW;
  localparam logic [UW-2:0] RECIP = (UW-1)'((64'd1 << UW) / 64'd3);
  localparam logic [UW-1:0] BIAS  = UW'(64'd3 << CB);

  logic [5:1] vld_q;

  // stage 1
  logic signed [DW-1:0]  a_d [3];
  logic signed [DW-1:0]  b_d [3];
  logic signed [SMW-1:0] sum_d [3];
  logic signed [DW-1:0]  a_q [3];
  logic signed [DW-1:0]  b_q [3];
  logic signed [SMW-1:0] sum_q [3];
  logic                  tri1_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (tri_i) begin
        a_d[j] = DW'($signed(vtx_i[1][j])) - DW'($signed(vtx_i[0][j]));
      end else begin
        a_d[j] = DW'($signed(vtx_i[3][j])) - DW'($signed(vtx_i[1][j]));
      end
      b_d[j] = DW'($signed(vtx_i[2][j])) - DW'($signed(vtx_i[0][j]));
      sum_d[j] = SMW'($signed(vtx_i[0][j])) + SMW'($signed(vtx_i[1][j]))
               + SMW'($signed(vtx_i[2][j]))
               + (tri_i ? SMW'(0) : SMW'($signed(vtx_i[3][j])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      b_q    <= b_d;
      sum_q  <= sum_d;
      tri1_q <= tri_i;
    end
  end

  // stage 2
  logic signed [PW-1:0] p_d [6];
  logic [UW-1:0]        u_d [3];
  logic [CB-1:0]        cq_d [3];
  logic signed [PW-1:0] p_q [6];
  logic [UW-1:0]        u2_q [3];
  logic [CB-1:0]        cq2_q [3];
  logic                 tri2_q;

  always_comb begin
    p_d[0] = PW'(a_q[1]) * PW'(b_q[2]);
    p_d[1] = PW'(a_q[2]) * PW'(b_q[1]);
    p_d[2] = PW'(a_q[2]) * PW'(b_q[0]);
    p_d[3] = PW'(a_q[0]) * PW'(b_q[2]);
    p_d[4] = PW'(a_q[0]) * PW'(b_q[1]);
    p_d[5] = PW'(a_q[1]) * PW'(b_q[0]);
    for (int j = 0; j < 3; j++) begin
      u_d[j]  = UW'(sum_q[j]) + BIAS;
      cq_d[j] = CB'(sum_q[j] >>> 2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= p_d;
      u2_q   <= u_d;
      cq2_q  <= cq_d;
      tri2_q <= tri1_q;
    end
  end

  // stage 3
  logic signed [XW-1:0] c_d [3];
  logic [MW-1:0]        mag_d [3];
  logic [2:0]           sgn_d;
  logic [RPW-1:0]       pr_d [3];
  logic [MW-1:0]        mag3_q [3];
  logic [2:0]           sgn3_q;
  logic                 degen3_q;
  logic [RPW-1:0]       pr3_q [3];
  logic [UW-1:0]        u3_q [3];
  logic [CB-1:0]        cq3_q [3];
  logic                 tri3_q;

  always_comb begin
    c_d[0] = XW'(p_q[0]) - XW'(p_q[1]);
    c_d[1] = XW'(p_q[2]) - XW'(p_q[3]);
    c_d[2] = XW'(p_q[4]) - XW'(p_q[5]);
    for (int j = 0; j < 3; j++) begin
      mag_d[j] = c_d[j][XW-1] ? MW'(-c_d[j]) : MW'(c_d[j]);
      sgn_d[j] = c_d[j][XW-1] ^ tri2_q;
      pr_d[j]  = RPW'(u2_q[j]) * RPW'(RECIP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag3_q   <= mag_d;
      sgn3_q   <= sgn_d;
      degen3_q <= (c_d[0] == '0) && (c_d[1] == '0) && (c_d[2] == '0);
      pr3_q    <= pr_d;
      u3_q     <= u2_q;
      cq3_q    <= cq2_q;
      tri3_q   <= tri2_q;
    end
  end

  // stage 4
  logic [2*HW-1:0]   hh_d [3];
  logic [HW+LW-1:0]  hl_d [3];
  logic [2*LW-1:0]   ll_d [3];
  logic [UW-2:0]     qe_d [3];
  logic [UW-2:0]     qc_d [3];
  logic [UW-1:0]     rm_d [3];
  logic [CB-1:0]     ctr_d [3];
  logic [2*HW-1:0]   hh_q [3];
  logic [HW+LW-1:0]  hl_q [3];
  logic [2*LW-1:0]   ll_q [3];
  logic [MW-1:0]     mag4_q [3];
  logic [2:0]        sgn4_q;
  logic              degen4_q;
  logic [CB-1:0]     ctr4_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      hh_d[j] = (2*HW)'(mag3_q[j][MW-1:LW]) * (2*HW)'(mag3_q[j][MW-1:LW]);
      hl_d[j] = (HW+LW)'(mag3_q[j][MW-1:LW]) * (HW+LW)'(mag3_q[j][LW-1:0]);
      ll_d[j] = (2*LW)'(mag3_q[j][LW-1:0]) * (2*LW)'(mag3_q[j][LW-1:0]);
      qe_d[j] = pr3_q[j][RPW-1:UW];
      rm_d[j] = u3_q[j] - UW'(qe_d[j]) * UW'(3);
      qc_d[j] = (rm_d[j] >= UW'(3)) ? qe_d[j] + (UW-1)'(1) : qe_d[j];
      ctr_d[j] = tri3_q ? qc_d[j][CB-1:0] : cq3_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q     <= hh_d;
      hl_q     <= hl_d;
      ll_q     <= ll_d;
      mag4_q   <= mag3_q;
      sgn4_q   <= sgn3_q;
      degen4_q <= degen3_q;
      ctr4_q   <= ctr_d;
    end
  end

  // stage 5
  logic [SW-1:0] sq_d;
  logic [SW-1:0] sq_q;
  logic [MW-1:0] mag5_q [3];
  logic [2:0]    sgn5_q;
  logic          degen5_q;
  logic [CB-1:0] ctr5_q [3];

  always_comb begin
    sq_d = '0;
    for (int j = 0; j < 3; j++) begin
      sq_d = sq_d + (SW'(hh_q[j]) << (2 * LW)) + (SW'(hl_q[j]) << (LW + 1))
           + SW'(ll_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q     <= sq_d;
      mag5_q   <= mag4_q;
      sgn5_q   <= sgn4_q;
      degen5_q <= degen4_q;
      ctr5_q   <= ctr4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:1], in_valid_i};
    end
  end

  assign ctrl_o = '{vld: vld_q[5], degen: degen5_q};
  assign sq_o   = sq_q;
  assign sgn_o  = sgn5_q;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag_o[j] = mag5_q[j];
      ctr_o[j] = ctr5_q[j];
    end
  end

endmodule

// ===== hdl/fanc_sqrt.sv =====
// Pipelined integer square root, one root bit per stage
`include "face_area_normal_centroid_top_defines.svh"
module fanc_sqrt #(
  parameter int unsigned RW  = 50,
  parameter int unsigned SBW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  fanc_pkg::ctrl_t   ctrl_i,
  input  logic [2*RW-1:0]   sq_i,
  input  logic [SBW-1:0]    side_i,
  output fanc_pkg::ctrl_t   ctrl_o,
  output logic [RW-1:0]     root_o,
  output logic [SBW-1:0]    side_o
);
  import fanc_pkg::*;

  ctrl_t           ctrl_q [RW];
  logic [RW:0]     rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] sq_q   [RW];
  logic [SBW-1:0]  side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    ctrl_t           ctrl_p;
    logic [RW:0]     rem_p;
    logic [RW-1:0]   root_p;
    logic [2*RW-1:0] sq_p;
    logic [SBW-1:0]  side_p;
    logic [RW+2:0]   tv;
    logic [RW+2:0]   trial;

    if (k == 0) begin : g_first
      assign ctrl_p = ctrl_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign sq_p   = sq_i;
      assign side_p = side_i;
    end else begin : g_next
      assign ctrl_p = ctrl_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign sq_p   = sq_q[k-1];
      assign side_p = side_q[k-1];
    end

    assign tv    = {rem_p, sq_p[2*RW-1 -: 2]};
    assign trial = {1'b0, root_p, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[k] <= '0;
      end else if (en_i) begin
        ctrl_q[k] <= ctrl_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (tv >= trial) begin
          rem_q[k]  <= (RW+1)'(tv - trial);
          root_q[k] <= {root_p[RW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= tv[RW:0];
          root_q[k] <= {root_p[RW-2:0], 1'b0};
        end
        sq_q[k]   <= {sq_p[2*RW-3:0], 2'b00};
        side_q[k] <= side_p;
      end
    end
  end

  assign ctrl_o = ctrl_q[RW-1];
  assign root_o = root_q[RW-1];
  assign side_o = side_q[RW-1];

  `FANC_ASSERT_NOW(a_root_nonzero, ctrl_o.vld && !ctrl_o.degen, root_o != '0, "zero root for a nonzero cross product")

endmodule

// ===== hdl/fanc_div.sv =====
// Pipelined normal division, rounding, clamping and output register
`include "face_area_normal_centroid_top_defines.svh"
module fanc_div #(
  parameter int unsigned RW  = 50,
  parameter int unsigned FB  = fanc_pkg::NORMAL_FRAC_BITS_DEF,
  parameter int unsigned SBW = 8
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  fanc_pkg::ctrl_t                            ctrl_i,
  input  logic [RW-1:0]                              m_i,
  input  logic [2:0][RW-1:0]                         mag_i,
  input  logic [2:0]                                 sgn_i,
  input  logic [SBW-1:0]                             side_i,
  output fanc_pkg::ctrl_t                            ctrl_o,
  output logic [fanc_pkg::AREA_BITS-1:0]             face_area_o,
  output logic [2:0][fanc_pkg::NORMAL_BITS-1:0]      normal_o,
  output logic [SBW-1:0]                             side_o
);
  import fanc_pkg::*;

  localparam int unsigned QW  = FB + 2;
  localparam int unsigned NS  = FB + 2;
  localparam int unsigned AXW = (RW - 1 > AREA_BITS) ? RW - 1 : AREA_BITS;
  localparam logic [31:0] HI_MAG = (FB >= NORMAL_BITS - 1) ?
                                   32'((64'd1 << (NORMAL_BITS - 1)) - 64'd1) :
                                   32'((64'd1 << FB) - 64'd1);
  localparam logic [31:0] LO_MAG = (FB >= NORMAL_BITS - 1) ?
                                   32'(64'd1 << (NORMAL_BITS - 1)) :
                                   32'(64'd1 << FB);

  ctrl_t            ctrl_q [NS];
  logic [RW-1:0]    m_q    [NS];
  logic [RW-1:0]    r_q    [NS][3];
  logic [QW-1:0]    q_q    [NS][3];
  logic [2:0]       sgn_q  [NS];
  logic [SBW-1:0]   side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    ctrl_t          ctrl_p;
    logic [RW-1:0]  m_p;
    logic [RW:0]    rt [3];
    logic [QW-1:0]  q_p [3];
    logic [2:0]     sgn_p;
    logic [SBW-1:0] side_p;

    if (k == 0) begin : g_first
      assign ctrl_p = ctrl_i;
      assign m_p    = m_i;
      assign sgn_p  = sgn_i;
      assign side_p = side_i;
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rt[j]  = {1'b0, mag_i[j]};
        assign q_p[j] = '0;
      end
    end else begin : g_next
      assign ctrl_p = ctrl_q[k-1];
      assign m_p    = m_q[k-1];
      assign sgn_p  = sgn_q[k-1];
      assign side_p = side_q[k-1];
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rt[j]  = {r_q[k-1][j], 1'b0};
        assign q_p[j] = q_q[k-1][j];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[k] <= '0;
      end else if (en_i) begin
        ctrl_q[k] <= ctrl_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k]    <= m_p;
        sgn_q[k]  <= sgn_p;
        side_q[k] <= side_p;
        for (int j = 0; j < 3; j++) begin
          if (rt[j] >= {1'b0, m_p}) begin
            r_q[k][j] <= RW'(rt[j] - {1'b0, m_p});
            q_q[k][j] <= {q_p[j][QW-2:0], 1'b1};
          end else begin
            r_q[k][j] <= rt[j][RW-1:0];
            q_q[k][j] <= {q_p[j][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // output stage
  logic [QW:0]            qr_d [3];
  logic [31:0]            lim_d [3];
  logic [31:0]            mm_d [3];
  logic [NORMAL_BITS-1:0] nrm_d [3];
  logic [AXW-1:0]         ax_d;
  logic [AREA_BITS-1:0]   area_d;
  ctrl_t                  out_ctrl_q;
  logic [AREA_BITS-1:0]   area_q;
  logic [NORMAL_BITS-1:0] nrm_q [3];
  logic [SBW-1:0]         out_side_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qr_d[j]  = ((QW+1)'(q_q[NS-1][j]) + (QW+1)'(1)) >> 1;
      lim_d[j] = sgn_q[NS-1][j] ? LO_MAG : HI_MAG;
      mm_d[j]  = (32'(qr_d[j]) > lim_d[j]) ? lim_d[j] : 32'(qr_d[j]);
      if (ctrl_q[NS-1].degen) begin
        nrm_d[j] = '0;
      end else if (sgn_q[NS-1][j]) begin
        nrm_d[j] = NORMAL_BITS'(-mm_d[j]);
      end else begin
        nrm_d[j] = NORMAL_BITS'(mm_d[j]);
      end
    end
    ax_d   = AXW'(m_q[NS-1] >> 1);
    area_d = (ax_d > AXW'({AREA_BITS{1'b1}})) ? {AREA_BITS{1'b1}} : ax_d[AREA_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ctrl_q <= '0;
    end else if (en_i) begin
      out_ctrl_q <= ctrl_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      area_q     <= area_d;
      nrm_q      <= nrm_d;
      out_side_q <= side_q[NS-1];
    end
  end

  assign ctrl_o      = out_ctrl_q;
  assign face_area_o = area_q;
  assign side_o      = out_side_q;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      normal_o[j] = nrm_q[j];
    end
  end

  `FANC_ASSERT_NOW(a_degen_area, ctrl_o.vld && ctrl_o.degen, face_area_o == '0, "degenerate face with nonzero area")
  `FANC_ASSERT_NOW(a_normal_set, ctrl_o.vld && !ctrl_o.degen, (normal_o[0] != '0) || (normal_o[1] != '0) || (normal_o[2] != '0), "zero normal on a regular face")
  `FANC_ASSERT_NEXT(a_degen_clear, ctrl_q[NS-1].vld && ctrl_q[NS-1].degen && en_i, (normal_o[0] == '0) && (normal_o[1] == '0) && (normal_o[2] == '0), "degenerate face with nonzero normal")

endmodule

// ===== hdl/face_area_normal_centroid_top.sv =====
// Face area, unit normal and centroid of one quad or triangle face per cycle.
// One face is accepted per clock; each result passes through the front
// stages, the square root and the normal divider with its output register.
// The square root resolves one root bit per stage, and the normal divider
// resolves one quotient bit per stage. A stalled output freezes the whole
// pipeline; bubbles are kept. face_kind selects quad (diagonal cross) or
// triangle (negated normal) and is written through the cfg port, which is
// always ready.
module face_area_normal_centroid_top #(
  parameter int unsigned COORD_BITS       = fanc_pkg::COORD_BITS_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = fanc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic                                  cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [COORD_BITS-1:0]          v0_x_i,
  input  logic signed [COORD_BITS-1:0]          v0_y_i,
  input  logic signed [COORD_BITS-1:0]          v0_z_i,
  input  logic signed [COORD_BITS-1:0]          v1_x_i,
  input  logic signed [COORD_BITS-1:0]          v1_y_i,
  input  logic signed [COORD_BITS-1:0]          v1_z_i,
  input  logic signed [COORD_BITS-1:0]          v2_x_i,
  input  logic signed [COORD_BITS-1:0]          v2_y_i,
  input  logic signed [COORD_BITS-1:0]          v2_z_i,
  input  logic signed [COORD_BITS-1:0]          v3_x_i,
  input  logic signed [COORD_BITS-1:0]          v3_y_i,
  input  logic signed [COORD_BITS-1:0]          v3_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [fanc_pkg::AREA_BITS-1:0]        face_area_o,
  output logic signed [fanc_pkg::NORMAL_BITS-1:0] normal_x_o,
  output logic signed [fanc_pkg::NORMAL_BITS-1:0] normal_y_o,
  output logic signed [fanc_pkg::NORMAL_BITS-1:0] normal_z_o,
  output logic signed [COORD_BITS-1:0]          center_x_o,
  output logic signed [COORD_BITS-1:0]          center_y_o,
  output logic signed [COORD_BITS-1:0]          center_z_o,
  output logic                                  degenerate_o
);
  import fanc_pkg::*;

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned MW  = 2 * CB + 1;
  localparam int unsigned RW  = MW + 1;
  localparam int unsigned SW  = 2 * RW;
  localparam int unsigned CTW = 3 * CB;
  localparam int unsigned SQB = 3 + 3 * MW + CTW;

  face_kind_e face_kind_q;
  logic       en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_kind_q <= FACE_QUAD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      face_kind_q <= face_kind_e'(cfg_data_i);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_o && out_stall_i;
  assign en          = !in_stall_o;

  logic [3:0][2:0][CB-1:0] vtx;
  assign vtx[0] = {v0_z_i, v0_y_i, v0_x_i};
  assign vtx[1] = {v1_z_i, v1_y_i, v1_x_i};
  assign vtx[2] = {v2_z_i, v2_y_i, v2_x_i};
  assign vtx[3] = {v3_z_i, v3_y_i, v3_x_i};

  ctrl_t              fr_ctrl;
  logic [SW-1:0]      fr_sq;
  logic [2:0][MW-1:0] fr_mag;
  logic [2:0]         fr_sgn;
  logic [2:0][CB-1:0] fr_ctr;

  fanc_front #(.CB(CB)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .tri_i      (face_kind_q == FACE_TRI),
    .vtx_i      (vtx),
    .ctrl_o     (fr_ctrl),
    .sq_o       (fr_sq),
    .mag_o      (fr_mag),
    .sgn_o      (fr_sgn),
    .ctr_o      (fr_ctr)
  );

  ctrl_t              rt_ctrl;
  logic [RW-1:0]      rt_root;
  logic [SQB-1:0]     rt_side;
  logic [2:0][MW-1:0] rt_mag;
  logic [2:0][RW-1:0] rt_mag_x;
  logic [2:0]         rt_sgn;
  logic [CTW-1:0]     rt_ctr;

  fanc_sqrt #(.RW(RW), .SBW(SQB)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctrl_i (fr_ctrl),
    .sq_i   (fr_sq),
    .side_i ({fr_sgn, fr_mag, fr_ctr}),
    .ctrl_o (rt_ctrl),
    .root_o (rt_root),
    .side_o (rt_side)
  );

  assign {rt_sgn, rt_mag, rt_ctr} = rt_side;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rt_mag_x[j] = RW'(rt_mag[j]);
    end
  end

  ctrl_t                        dv_ctrl;
  logic [2:0][NORMAL_BITS-1:0]  dv_nrm;
  logic [2:0][CB-1:0]           dv_ctr;

  fanc_div #(.RW(RW), .FB(NORMAL_FRAC_BITS), .SBW(CTW)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctrl_i      (rt_ctrl),
    .m_i         (rt_root),
    .mag_i       (rt_mag_x),
    .sgn_i       (rt_sgn),
    .side_i      (rt_ctr),
    .ctrl_o      (dv_ctrl),
    .face_area_o (face_area_o),
    .normal_o    (dv_nrm),
    .side_o      (dv_ctr)
  );

  assign out_valid_o  = dv_ctrl.vld;
  assign degenerate_o = dv_ctrl.degen;
  assign normal_x_o   = dv_nrm[0];
  assign normal_y_o   = dv_nrm[1];
  assign normal_z_o   = dv_nrm[2];
  assign center_x_o   = dv_ctr[0];
  assign center_y_o   = dv_ctr[1];
  assign center_z_o   = dv_ctr[2];

endmodule
